@@ rtl/cps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_pkg
// Shared types and constants for the closest-point-on-segment core.
// ----------------------------------------------------------------------------
package cps_pkg;

  // Width of the position code on the result port
  localparam int unsigned PosCodeWidth = 2;

  // Where the projection landed on the segment
  typedef enum logic [PosCodeWidth-1:0] {
    POS_INTERIOR = 2'd0,
    POS_START    = 2'd1,
    POS_END      = 2'd2,
    POS_ZERO_LEN = 2'd3
  } pos_code_e;

endpackage : cps_pkg

@@ rtl/closest_point_on_segment_core.sv @@
`timescale 1ns / 1ps
// An accepted start passes the difference, product and sum stages, the divider
// registers, the scale stage and the output stage before the result strobe.
// Throughput: one beat per cycle; busy stays low and the receiver cannot stall,
// so a new item may enter every cycle.
// The restoring divider for the projection parameter sets the depth: one
// quotient bit per pipeline stage. Reset clears all stage valid bits at once.
// ----------------------------------------------------------------------------
// closest_point_on_segment_core
// Projects a query point onto a segment, clamps the parameter to [0,1] and
// returns the nearest point, the fixed-point parameter and a position code.
// ----------------------------------------------------------------------------
module closest_point_on_segment_core
  import cps_pkg::*;
#(
  parameter int unsigned COORD_WIDTH   = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [COORD_WIDTH-1:0]  start_x_i,
  input  logic signed [COORD_WIDTH-1:0]  start_y_i,
  input  logic signed [COORD_WIDTH-1:0]  end_x_i,
  input  logic signed [COORD_WIDTH-1:0]  end_y_i,
  input  logic signed [COORD_WIDTH-1:0]  query_x_i,
  input  logic signed [COORD_WIDTH-1:0]  query_y_i,
  output logic                           result_valid_o,
  output logic signed [COORD_WIDTH-1:0]  nearest_x_o,
  output logic signed [COORD_WIDTH-1:0]  nearest_y_o,
  output logic [FRACTION_BITS:0]         param_fraction_o,
  output logic [PosCodeWidth-1:0]        position_code_o
);

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned FB  = FRACTION_BITS;
  localparam int unsigned DW  = CW + 1;          // coordinate difference
  localparam int unsigned PW  = 2 * DW;          // product of two differences
  localparam int unsigned SW  = PW + 1;          // signed dot product
  localparam int unsigned MW  = 2 * CW + 2;      // squared length, remainder
  localparam int unsigned TW  = FB + 1;          // parameter with integer bit
  localparam int unsigned XW  = DW + TW + 1;     // difference times parameter
  localparam int unsigned LAT = FB + 6;

  localparam logic [TW-1:0] TOne = {1'b1, {FB{1'b0}}};
  localparam logic signed [XW-1:0] Half =
    {{(XW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};

  logic accept;
  assign accept = start & ~busy;
  assign busy   = 1'b0;

  // --------------------------------------------------------------------------
  // Stage 1: differences
  // --------------------------------------------------------------------------
  logic                 s1_valid_q;
  logic signed [DW-1:0] s1_dx_q, s1_dy_q, s1_px_q, s1_py_q;
  logic [CW-1:0]        s1_ax_q, s1_ay_q;

  always_ff @(posedge clk_i) begin
    s1_dx_q <= {end_x_i[CW-1], end_x_i} - {start_x_i[CW-1], start_x_i};
    s1_dy_q <= {end_y_i[CW-1], end_y_i} - {start_y_i[CW-1], start_y_i};
    s1_px_q <= {query_x_i[CW-1], query_x_i} - {start_x_i[CW-1], start_x_i};
    s1_py_q <= {query_y_i[CW-1], query_y_i} - {start_y_i[CW-1], start_y_i};
    s1_ax_q <= start_x_i;
    s1_ay_q <= start_y_i;
  end

  // --------------------------------------------------------------------------
  // Stage 2: four products
  // --------------------------------------------------------------------------
  logic                 s2_valid_q;
  logic signed [PW-1:0] s2_dxx_q, s2_dyy_q, s2_pdx_q, s2_pdy_q;
  logic signed [DW-1:0] s2_dx_q, s2_dy_q;
  logic [CW-1:0]        s2_ax_q, s2_ay_q;

  always_ff @(posedge clk_i) begin
    s2_dxx_q <= PW'(s1_dx_q) * PW'(s1_dx_q);
    s2_dyy_q <= PW'(s1_dy_q) * PW'(s1_dy_q);
    s2_pdx_q <= PW'(s1_px_q) * PW'(s1_dx_q);
    s2_pdy_q <= PW'(s1_py_q) * PW'(s1_dy_q);
    s2_dx_q  <= s1_dx_q;
    s2_dy_q  <= s1_dy_q;
    s2_ax_q  <= s1_ax_q;
    s2_ay_q  <= s1_ay_q;
  end

  // --------------------------------------------------------------------------
  // Stage 3: squared length and dot product
  // --------------------------------------------------------------------------
  logic                 s3_valid_q;
  logic [MW-1:0]        s3_mag_q;
  logic signed [SW-1:0] s3_dot_q;
  logic signed [DW-1:0] s3_dx_q, s3_dy_q;
  logic [CW-1:0]        s3_ax_q, s3_ay_q;

  always_ff @(posedge clk_i) begin
    s3_mag_q <= s2_dxx_q + s2_dyy_q;
    s3_dot_q <= {s2_pdx_q[PW-1], s2_pdx_q} + {s2_pdy_q[PW-1], s2_pdy_q};
    s3_dx_q  <= s2_dx_q;
    s3_dy_q  <= s2_dy_q;
    s3_ax_q  <= s2_ax_q;
    s3_ay_q  <= s2_ay_q;
  end

  // --------------------------------------------------------------------------
  // Stage 4: classify, seed the divider
  // --------------------------------------------------------------------------
  logic      cl_zero, cl_neg, cl_past, cl_eq;
  pos_code_e cl_code;
  logic [TW-1:0] cl_t;
  logic [MW-1:0] cl_rem;

  always_comb begin
    cl_zero = (s3_mag_q == '0);
    cl_neg  = s3_dot_q[SW-1];
    cl_past = s3_dot_q > $signed({1'b0, s3_mag_q});
    cl_eq   = (s3_dot_q == $signed({1'b0, s3_mag_q}));
    cl_t    = '0;
    cl_rem  = '0;
    priority if (cl_zero) begin
      cl_code = POS_ZERO_LEN;
    end else if (cl_neg) begin
      cl_code = POS_START;
    end else if (cl_past) begin
      cl_code = POS_END;
      cl_t    = TOne;
    end else begin
      cl_code = POS_INTERIOR;
      if (cl_eq) begin
        cl_t = TW'(1);
      end else begin
        cl_rem = s3_dot_q[MW-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 5..: restoring divider, one quotient bit per stage
  // --------------------------------------------------------------------------
  logic                 dv_valid_q [FB+1];
  logic [MW-1:0]        dv_rem_q   [FB+1];
  logic [MW-1:0]        dv_rem_d   [FB+1];
  logic [TW-1:0]        dv_t_q     [FB+1];
  logic [TW-1:0]        dv_t_d     [FB+1];
  logic [MW-1:0]        dv_mag_q   [FB+1];
  pos_code_e            dv_code_q  [FB+1];
  logic signed [DW-1:0] dv_dx_q    [FB+1];
  logic signed [DW-1:0] dv_dy_q    [FB+1];
  logic [CW-1:0]        dv_ax_q    [FB+1];
  logic [CW-1:0]        dv_ay_q    [FB+1];

  always_comb begin
    logic [MW:0] shifted;
    logic [MW:0] diff;
    dv_rem_d[0] = cl_rem;
    dv_t_d[0]   = cl_t;
    for (int i = 1; i <= FB; i++) begin
      shifted = {dv_rem_q[i-1], 1'b0};
      diff    = shifted - {1'b0, dv_mag_q[i-1]};
      if (dv_code_q[i-1] != POS_INTERIOR) begin
        dv_rem_d[i] = dv_rem_q[i-1];
        dv_t_d[i]   = dv_t_q[i-1];
      end else if (!diff[MW]) begin
        dv_rem_d[i] = diff[MW-1:0];
        dv_t_d[i]   = {dv_t_q[i-1][TW-2:0], 1'b1};
      end else begin
        dv_rem_d[i] = shifted[MW-1:0];
        dv_t_d[i]   = {dv_t_q[i-1][TW-2:0], 1'b0};
      end
    end
  end

  // advance divider payload
  always_ff @(posedge clk_i) begin
    dv_rem_q[0]  <= dv_rem_d[0];
    dv_t_q[0]    <= dv_t_d[0];
    dv_mag_q[0]  <= s3_mag_q;
    dv_code_q[0] <= cl_code;
    dv_dx_q[0]   <= s3_dx_q;
    dv_dy_q[0]   <= s3_dy_q;
    dv_ax_q[0]   <= s3_ax_q;
    dv_ay_q[0]   <= s3_ay_q;
    for (int i = 1; i <= FB; i++) begin
      dv_rem_q[i]  <= dv_rem_d[i];
      dv_t_q[i]    <= dv_t_d[i];
      dv_mag_q[i]  <= dv_mag_q[i-1];
      dv_code_q[i] <= dv_code_q[i-1];
      dv_dx_q[i]   <= dv_dx_q[i-1];
      dv_dy_q[i]   <= dv_dy_q[i-1];
      dv_ax_q[i]   <= dv_ax_q[i-1];
      dv_ay_q[i]   <= dv_ay_q[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Scale stage: difference times parameter
  // --------------------------------------------------------------------------
  logic                 sc_valid_q;
  logic signed [XW-1:0] sc_px_q, sc_py_q;
  logic [TW-1:0]        sc_t_q;
  pos_code_e            sc_code_q;
  logic [CW-1:0]        sc_ax_q, sc_ay_q;
  logic signed [TW:0]   sc_t_s;

  assign sc_t_s = {1'b0, dv_t_q[FB]};

  always_ff @(posedge clk_i) begin
    sc_px_q   <= XW'(dv_dx_q[FB]) * XW'(sc_t_s);
    sc_py_q   <= XW'(dv_dy_q[FB]) * XW'(sc_t_s);
    sc_t_q    <= dv_t_q[FB];
    sc_code_q <= dv_code_q[FB];
    sc_ax_q   <= dv_ax_q[FB];
    sc_ay_q   <= dv_ay_q[FB];
  end

  // --------------------------------------------------------------------------
  // Output stage: round to nearest, ties up, and offset by the start point
  // --------------------------------------------------------------------------
  logic                 out_valid_q;
  logic [CW-1:0]        out_x_q, out_y_q;
  logic [TW-1:0]        out_t_q;
  pos_code_e            out_code_q;
  logic signed [XW-1:0] rnd_x, rnd_y;

  assign rnd_x = (sc_px_q + Half) >>> FB;
  assign rnd_y = (sc_py_q + Half) >>> FB;

  always_ff @(posedge clk_i) begin
    out_x_q    <= sc_ax_q + rnd_x[CW-1:0];
    out_y_q    <= sc_ay_q + rnd_y[CW-1:0];
    out_t_q    <= sc_t_q;
    out_code_q <= sc_code_q;
  end

  // --------------------------------------------------------------------------
  // Valid bits: advance every cycle, clear on reset
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      sc_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i <= FB; i++) begin
        dv_valid_q[i] <= 1'b0;
      end
    end else begin
      s1_valid_q    <= accept;
      s2_valid_q    <= s1_valid_q;
      s3_valid_q    <= s2_valid_q;
      dv_valid_q[0] <= s3_valid_q;
      for (int i = 1; i <= FB; i++) begin
        dv_valid_q[i] <= dv_valid_q[i-1];
      end
      sc_valid_q    <= dv_valid_q[FB];
      out_valid_q   <= sc_valid_q;
    end
  end

  assign result_valid_o   = out_valid_q;
  assign nearest_x_o      = out_x_q;
  assign nearest_y_o      = out_y_q;
  assign param_fraction_o = out_t_q;
  assign position_code_o  = out_code_q;

`ifndef NO_ASSERTIONS
  // Every accepted beat shows up as a result strobe at the end of the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT result_valid_o)
    else $error("result strobe missing after accepted beat");

  // Start and zero-length results carry a zero parameter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (out_code_q == POS_START || out_code_q == POS_ZERO_LEN)
      |-> param_fraction_o == '0)
    else $error("clamped-to-start result with nonzero parameter");

  // End results carry a parameter of exactly one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && out_code_q == POS_END |-> param_fraction_o == TOne)
    else $error("clamped-to-end result with parameter not one");

  // Interior parameter never exceeds one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && out_code_q == POS_INTERIOR |-> param_fraction_o <= TOne)
    else $error("interior parameter above one");
`endif

endmodule : closest_point_on_segment_core
